// ----- hdl/fgs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fgs_pkg;

    // field widths
    localparam int SIZE_W    = 12;
    localparam int ROOTENT_W = 13;
    localparam int RSV_W     = 7;
    localparam int SPC_W     = 7;
    localparam int LOG_W     = 3;
    localparam int FAT_W     = 10;
    localparam int ROOT_W    = 10;
    localparam int OVH_W     = 12;
    localparam int CLUS_W    = 23;
    localparam int TOT_W     = 23;
    localparam int NEED_W    = 16;
    localparam int ITER_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 13;

    // layout limits
    localparam logic [SIZE_W-1:0] SIZE_MIN          = 12'd4;
    localparam logic [SIZE_W-1:0] SIZE_MAX          = 12'd2048;
    localparam logic [CLUS_W-1:0] MIN_CLUSTERS      = 23'd4085;
    localparam logic [CLUS_W-1:0] MAX_CLUSTERS_EXCL = 23'd65525;
    localparam logic [LOG_W-1:0]  SPC_LOG_INIT      = 3'd2;   // 4 sectors
    localparam logic [LOG_W-1:0]  SPC_LOG_MAX       = 3'd6;   // 64 sectors
    localparam logic [ITER_W-1:0] ITER_LAST         = 8'd255;

    // reset values of the configuration registers
    localparam logic [ROOTENT_W-1:0] ROOT_ENTRIES_RST = 13'd512;
    localparam logic [RSV_W-1:0]     RESERVED_RST     = 7'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROOT_ENTRIES = 1'b0,
        CFG_RESERVED     = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_SMALL   = 2'd2,
        ST_UNREACH = 2'd3
    } t_status;

    // outcome of one iteration
    typedef enum logic [2:0] {
        ACT_SMALL,
        ACT_GROW_SPC,
        ACT_SHRINK_SPC,
        ACT_GROW_FAT,
        ACT_END
    } t_act;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DECIDE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;        // latch request, init iteration
        logic calc;        // register cluster count
        logic step;        // apply iteration update
        logic finish;      // capture result of iteration
        logic fail_range;  // capture out-of-range result
    } t_dp_cmd;

    typedef struct packed {
        logic range_bad;
        t_act act;
        logic guard_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hdl/fat16_geometry_solver.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Signals                                        | Beat taken when
// ----------+------------------------------------------------+--------------------------
// request   | i_start, o_busy, i_size_mib                    | i_start && !o_busy
// result    | o_done, o_status, o_sectors_per_cluster,       | o_done (one cycle)
//           | o_fat_sectors, o_cluster_count, o_total_sectors|
// config    | i_cfg_valid, o_cfg_ready, i_cfg_index,         | i_cfg_valid && o_cfg_ready
//           | i_cfg_data                                     |
//
// One request at a time. Each layout iteration passes S_CALC (cluster count),
// then S_DECIDE (decision); the iteration count is a handful, guarded at 256.
// A size out of range goes from S_CALC straight to S_DONE, which raises o_done.
// S_DONE leads back to S_IDLE before the next request can be taken.
// Synchronous active-low reset: controller goes idle, root_entries = 512,
// reserved_sectors = 1. The result receiver cannot stall; config is always ready.

module fat16_geometry_solver (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_start,
    output logic                              o_busy,
    input  wire  [fgs_pkg::SIZE_W-1:0]        i_size_mib,
    output logic                              o_done,
    output logic [1:0]                        o_status,
    output logic [fgs_pkg::SPC_W-1:0]         o_sectors_per_cluster,
    output logic [fgs_pkg::FAT_W-1:0]         o_fat_sectors,
    output logic [fgs_pkg::CLUS_W-1:0]        o_cluster_count,
    output logic [fgs_pkg::TOT_W-1:0]         o_total_sectors,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [fgs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [fgs_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import fgs_pkg::*;

    logic [ROOTENT_W-1:0] r_root_entries;
    logic [ROOTENT_W-1:0] n_root_entries;
    logic [RSV_W-1:0]     r_reserved_sectors;
    logic [RSV_W-1:0]     n_reserved_sectors;
    t_dp_cmd              w_cmd;
    t_dp_stat             w_stat;

    assign o_cfg_ready = 1'b1;

    // config register decode
    always_comb begin
        n_root_entries     = r_root_entries;
        n_reserved_sectors = r_reserved_sectors;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROOT_ENTRIES: n_root_entries     = i_cfg_data[ROOTENT_W-1:0];
                CFG_RESERVED:     n_reserved_sectors = i_cfg_data[RSV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_entries     <= ROOT_ENTRIES_RST;
            r_reserved_sectors <= RESERVED_RST;
        end else begin
            r_root_entries     <= n_root_entries;
            r_reserved_sectors <= n_reserved_sectors;
        end
    end

    fgs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    fgs_dpath u_dpath (
        .i_clk                 (i_clk),
        .i_cmd                 (w_cmd),
        .i_size_mib            (i_size_mib),
        .i_root_entries        (r_root_entries),
        .i_reserved_sectors    (r_reserved_sectors),
        .o_stat                (w_stat),
        .o_status              (o_status),
        .o_sectors_per_cluster (o_sectors_per_cluster),
        .o_fat_sectors         (o_fat_sectors),
        .o_cluster_count       (o_cluster_count),
        .o_total_sectors       (o_total_sectors)
    );

endmodule

`default_nettype wire

// ----- hdl/fgs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fgs_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  fgs_pkg::t_dp_stat  i_stat,
    output fgs_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy,
    output logic               o_done
);
    import fgs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_end;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // iteration stops on a failure, a settled layout or the guard
    assign w_end = (i_stat.act == ACT_SMALL) || (i_stat.act == ACT_END) || i_stat.guard_last;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                if (i_stat.range_bad) begin
                    o_cmd.fail_range = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.calc = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.step = 1'b1;
                if (w_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_CALC;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

`default_nettype wire

// ----- hdl/fgs_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fgs_dpath (
    input  wire                              i_clk,
    input  fgs_pkg::t_dp_cmd                 i_cmd,
    input  wire [fgs_pkg::SIZE_W-1:0]        i_size_mib,
    input  wire [fgs_pkg::ROOTENT_W-1:0]     i_root_entries,
    input  wire [fgs_pkg::RSV_W-1:0]         i_reserved_sectors,
    output fgs_pkg::t_dp_stat                o_stat,
    output logic [1:0]                       o_status,
    output logic [fgs_pkg::SPC_W-1:0]        o_sectors_per_cluster,
    output logic [fgs_pkg::FAT_W-1:0]        o_fat_sectors,
    output logic [fgs_pkg::CLUS_W-1:0]       o_cluster_count,
    output logic [fgs_pkg::TOT_W-1:0]        o_total_sectors
);
    import fgs_pkg::*;

    // iteration state
    logic [SIZE_W-1:0]  r_size;
    logic [LOG_W-1:0]   r_spc_log;
    logic [LOG_W-1:0]   n_spc_log;
    logic [FAT_W-1:0]   r_fat;
    logic [FAT_W-1:0]   n_fat;
    logic [CLUS_W-1:0]  r_clusters;
    logic               r_small;
    logic [ITER_W-1:0]  r_iter;

    // result registers
    t_status            r_res_status;
    logic [SPC_W-1:0]   r_res_spc;
    logic [FAT_W-1:0]   r_res_fat;
    logic [CLUS_W-1:0]  r_res_clusters;
    logic [TOT_W-1:0]   r_res_total;

    logic [TOT_W-1:0]     w_total;
    logic [ROOTENT_W:0]   w_root_sum;
    logic [ROOT_W-1:0]    w_root;
    logic [OVH_W-1:0]     w_overhead;
    logic                 w_small;
    logic [CLUS_W-1:0]    w_diff;
    logic [CLUS_W-1:0]    w_clusters;
    logic [CLUS_W:0]      w_need_sum;
    logic [NEED_W-1:0]    w_need;
    logic                 w_hi;
    logic                 w_lo;
    t_act                 w_act;
    t_status              w_status;

    // size * 2048, root dir sectors = ceil(entries / 16)
    assign w_total    = {r_size, 11'b0};
    assign w_root_sum = {1'b0, i_root_entries} + (ROOTENT_W+1)'(15);
    assign w_root     = w_root_sum[ROOTENT_W:4];

    // overhead with two FAT copies, data clusters by shift
    assign w_overhead = OVH_W'(i_reserved_sectors) + OVH_W'({r_fat, 1'b0}) + OVH_W'(w_root);
    assign w_small    = (TOT_W'(w_overhead) >= w_total);
    assign w_diff     = w_total - TOT_W'(w_overhead);
    assign w_clusters = w_diff >> r_spc_log;

    // FAT sectors needed: ceil((clusters + 2) * 2 / 512) == (clusters + 257) >> 8
    assign w_need_sum = {1'b0, r_clusters} + (CLUS_W+1)'(257);
    assign w_need     = w_need_sum[CLUS_W:8];

    assign w_hi = (r_clusters >= MAX_CLUSTERS_EXCL);
    assign w_lo = (r_clusters < MIN_CLUSTERS);

    // iteration decision
    always_comb begin
        if (r_small) begin
            w_act = ACT_SMALL;
        end else if (w_hi && (r_spc_log < SPC_LOG_MAX)) begin
            w_act = ACT_GROW_SPC;
        end else if (w_lo && (r_spc_log != '0)) begin
            w_act = ACT_SHRINK_SPC;
        end else if (w_need > NEED_W'(r_fat)) begin
            w_act = ACT_GROW_FAT;
        end else begin
            w_act = ACT_END;
        end
    end

    // next cluster size and FAT size
    always_comb begin
        n_spc_log = r_spc_log;
        n_fat     = r_fat;
        case (w_act)
            ACT_GROW_SPC: begin
                n_spc_log = r_spc_log + LOG_W'(1);
                n_fat     = FAT_W'(1);
            end
            ACT_SHRINK_SPC: begin
                n_spc_log = r_spc_log - LOG_W'(1);
                n_fat     = FAT_W'(1);
            end
            ACT_GROW_FAT: begin
                // clusters stay at most 65536 here, so need fits
                n_fat = w_need[FAT_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // status of the iteration that ends the search
    always_comb begin
        case (w_act)
            ACT_SMALL: w_status = ST_SMALL;
            ACT_END:   w_status = (w_hi || w_lo) ? ST_UNREACH : ST_OK;
            default:   w_status = ST_UNREACH;  // guard ran out
        endcase
    end

    // iteration registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_size    <= i_size_mib;
            r_spc_log <= SPC_LOG_INIT;
            r_fat     <= FAT_W'(1);
            r_iter    <= '0;
        end else if (i_cmd.step) begin
            r_spc_log <= n_spc_log;
            r_fat     <= n_fat;
            r_iter    <= r_iter + ITER_W'(1);
        end
        if (i_cmd.calc) begin
            r_small    <= w_small;
            r_clusters <= w_small ? '0 : w_clusters;
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.fail_range) begin
            r_res_status   <= ST_RANGE;
            r_res_spc      <= '0;
            r_res_fat      <= '0;
            r_res_clusters <= '0;
            r_res_total    <= w_total;
        end else if (i_cmd.finish) begin
            r_res_status   <= w_status;
            r_res_spc      <= SPC_W'(1) << n_spc_log;
            r_res_fat      <= n_fat;
            r_res_clusters <= r_clusters;
            r_res_total    <= w_total;
        end
    end

    assign o_stat.range_bad  = (r_size < SIZE_MIN) || (r_size > SIZE_MAX);
    assign o_stat.act        = w_act;
    assign o_stat.guard_last = (r_iter == ITER_LAST);

    assign o_status              = r_res_status;
    assign o_sectors_per_cluster = r_res_spc;
    assign o_fat_sectors         = r_res_fat;
    assign o_cluster_count       = r_res_clusters;
    assign o_total_sectors       = r_res_total;

endmodule

`default_nettype wire

// ----- hdl/fgs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fgs_checker (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_start,
    input  wire                               o_busy,
    input  wire                               o_done,
    input  wire  [1:0]                        o_status,
    input  wire  [fgs_pkg::SPC_W-1:0]         o_sectors_per_cluster,
    input  wire  [fgs_pkg::FAT_W-1:0]         o_fat_sectors,
    input  wire  [fgs_pkg::CLUS_W-1:0]        o_cluster_count
);
    import fgs_pkg::*;

    // a result beat shows while the request is still held busy
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy)
        else $error("result strobe outside a busy request");

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_done))
        else $error("accepted request did not start");

    // one result beat per request, then idle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !o_busy))
        else $error("result strobe longer than one cycle");

    // size out of range reports an empty layout
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_RANGE)) |->
        ((o_sectors_per_cluster == '0) && (o_fat_sectors == '0) && (o_cluster_count == '0)))
        else $error("out-of-range result carries layout fields");

    // a good layout has a FAT16 cluster count
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_OK)) |->
        ((o_cluster_count >= MIN_CLUSTERS) && (o_cluster_count < MAX_CLUSTERS_EXCL)))
        else $error("ok status with cluster count outside FAT16 range");

endmodule

bind fat16_geometry_solver fgs_checker u_fgs_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_start               (i_start),
    .o_busy                (o_busy),
    .o_done                (o_done),
    .o_status              (o_status),
    .o_sectors_per_cluster (o_sectors_per_cluster),
    .o_fat_sectors         (o_fat_sectors),
    .o_cluster_count       (o_cluster_count)
);

`default_nettype wire

// ----- verif/fat16_geometry_solver_test.sv -----
`timescale 1ns / 1ps

module fat16_geometry_solver_test;
    import fgs_pkg::*;

    // layout arithmetic constants
    localparam int unsigned SECTORS_PER_MIB = 2048;
    localparam int unsigned SECTOR_BYTES    = 512;
    localparam int unsigned DIR_ENTRY_BYTES = 32;
    localparam int unsigned FAT_ENTRY_BYTES = 2;
    localparam int unsigned RSVD_CLUSTERS   = 2;
    localparam int unsigned SPC_START       = 4;
    localparam int unsigned SPC_CAP         = 64;
    localparam int unsigned STEP_GUARD      = 256;

    // run control
    localparam int IDLE_PCT     = 16;
    localparam int QUIET_FROM   = 400;
    localparam int QUIET_TO     = 600;
    localparam int PHASE_REQS   = 140;
    localparam int TAIL_CYCLES  = 64;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int MAX_REPORTS  = 40;

    typedef enum logic [1:0] {
        JOB_REQ,
        JOB_REG,
        JOB_DRAIN
    } t_job_kind;

    typedef struct {
        t_job_kind             kind;
        logic [SIZE_W-1:0]     size;
        t_cfg_idx              idx;
        logic [CFG_DAT_W-1:0]  data;
    } t_job;

    typedef struct {
        t_status               status;
        logic [SPC_W-1:0]      spc;
        logic [FAT_W-1:0]      fat;
        logic [CLUS_W-1:0]     clusters;
        logic [TOT_W-1:0]      total;
    } t_layout;

    // DUT signals
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic [SIZE_W-1:0]     i_size_mib = '0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data = '0;
    logic                  o_busy;
    logic                  o_done;
    logic [1:0]            o_status;
    logic [SPC_W-1:0]      o_sectors_per_cluster;
    logic [FAT_W-1:0]      o_fat_sectors;
    logic [CLUS_W-1:0]     o_cluster_count;
    logic [TOT_W-1:0]      o_total_sectors;
    logic                  o_cfg_ready;

    // stimulus and scoreboard
    t_job                  job_q[$];
    t_job                  job;
    t_layout               layout_q[$];
    t_layout               want;
    logic [ROOTENT_W-1:0]  root_entries_reg = ROOT_ENTRIES_RST;
    logic [RSV_W-1:0]      reserved_reg = RESERVED_RST;

    int  n_err = 0;
    int  n_checked = 0;
    int  n_writes = 0;
    int  n_sent = 0;
    int  n_cycles = 0;
    int  open_reqs = 0;
    int  outcome_hits[4] = '{0, 0, 0, 0};
    bit  want_start;
    bit  want_cfg;
    bit  pause;

    fat16_geometry_solver u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_start               (i_start),
        .o_busy                (o_busy),
        .i_size_mib            (i_size_mib),
        .o_done                (o_done),
        .o_status              (o_status),
        .o_sectors_per_cluster (o_sectors_per_cluster),
        .o_fat_sectors         (o_fat_sectors),
        .o_cluster_count       (o_cluster_count),
        .o_total_sectors       (o_total_sectors),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Layout search: adjust cluster size until the count fits FAT16,
    // then grow the FAT until it maps every cluster.
    function automatic t_layout solve_layout(input logic [SIZE_W-1:0] size_mib);
        int unsigned total;
        int unsigned root;
        int unsigned rsv;
        int unsigned spc;
        int unsigned fat;
        int unsigned clus;
        int unsigned ovh;
        int unsigned need;
        int unsigned step;
        bit          stop;
        t_status     status;
        t_layout     res;
        total = {20'd0, size_mib} * SECTORS_PER_MIB;
        root  = ({19'd0, root_entries_reg} * DIR_ENTRY_BYTES + SECTOR_BYTES - 1) / SECTOR_BYTES;
        rsv   = {25'd0, reserved_reg};
        spc   = SPC_START;
        fat   = 1;
        clus  = 0;
        stop  = 1'b0;
        if (size_mib < SIZE_MIN || size_mib > SIZE_MAX) begin
            status = ST_RANGE;
            spc = 0;
            fat = 0;
        end else begin
            status = ST_UNREACH;
            for (step = 0; step < STEP_GUARD && !stop; step++) begin
                ovh = rsv + 2 * fat + root;
                if (ovh >= total) begin
                    status = ST_SMALL;
                    clus = 0;
                    stop = 1'b1;
                end else begin
                    clus = (total - ovh) / spc;
                    if (clus >= MAX_CLUSTERS_EXCL && spc < SPC_CAP) begin
                        spc = spc * 2;
                        fat = 1;
                    end else if (clus < MIN_CLUSTERS && spc > 1) begin
                        spc = spc / 2;
                        fat = 1;
                    end else begin
                        need = ((clus + RSVD_CLUSTERS) * FAT_ENTRY_BYTES + SECTOR_BYTES - 1)
                               / SECTOR_BYTES;
                        if (need > fat) begin
                            fat = need;
                        end else begin
                            status = (clus < MIN_CLUSTERS || clus >= MAX_CLUSTERS_EXCL) ?
                                     ST_UNREACH : ST_OK;
                            stop = 1'b1;
                        end
                    end
                end
            end
        end
        res.status   = status;
        res.spc      = spc[SPC_W-1:0];
        res.fat      = fat[FAT_W-1:0];
        res.clusters = clus[CLUS_W-1:0];
        res.total    = total[TOT_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string what, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            n_err++;
            if (n_err <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
        end
    endtask

    task automatic push_request(input logic [SIZE_W-1:0] size);
        t_job j;
        j.kind = JOB_REQ;
        j.size = size;
        j.idx  = CFG_ROOT_ENTRIES;
        j.data = '0;
        job_q.push_back(j);
    endtask

    task automatic push_reg_write(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] data);
        t_job j;
        j.kind = JOB_REG;
        j.size = '0;
        j.idx  = idx;
        j.data = data;
        job_q.push_back(j);
    endtask

    task automatic push_drain();
        t_job j;
        j.kind = JOB_DRAIN;
        j.size = '0;
        j.idx  = CFG_ROOT_ENTRIES;
        j.data = '0;
        job_q.push_back(j);
    endtask

    // mostly in-range sizes, weighted toward both ends, with some out of range
    function automatic logic [SIZE_W-1:0] rand_size();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return SIZE_W'($urandom_range(SIZE_MIN - 1, 0));
        else if (pick < 16)
            return SIZE_W'($urandom_range((1 << SIZE_W) - 1, SIZE_MAX + 1));
        else if (pick < 30)
            return SIZE_W'($urandom_range(64, SIZE_MIN));
        else if (pick < 40)
            return SIZE_W'($urandom_range(SIZE_MAX, SIZE_MAX - 64));
        else
            return SIZE_W'($urandom_range(SIZE_MAX, SIZE_MIN));
    endfunction

    // Driver: one beat per handshake, random idle cycles outside the quiet window.
    // Register writes and drain points wait until every result is back.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy)
                open_reqs++;
            if (o_done)
                open_reqs--;
            if (!(i_start && o_busy) && !(i_cfg_valid && !o_cfg_ready)) begin
                want_start = 1'b0;
                want_cfg   = 1'b0;
                pause = (n_sent < QUIET_FROM || n_sent >= QUIET_TO) &&
                        ($urandom_range(99) < IDLE_PCT);
                if (job_q.size() > 0 && !pause) begin
                    if (job_q[0].kind == JOB_REQ) begin
                        job = job_q.pop_front();
                        want_start = 1'b1;
                        i_size_mib <= job.size;
                        n_sent++;
                    end else if (open_reqs == 0 && !o_busy) begin
                        job = job_q.pop_front();
                        if (job.kind == JOB_REG) begin
                            want_cfg = 1'b1;
                            i_cfg_index <= job.idx;
                            i_cfg_data  <= job.data;
                        end
                    end
                end
                if (!want_start)
                    i_size_mib <= SIZE_W'($urandom);
                if (!want_cfg) begin
                    i_cfg_index <= CFG_IDX_W'($urandom);
                    i_cfg_data  <= CFG_DAT_W'($urandom);
                end
                i_start     <= want_start;
                i_cfg_valid <= want_cfg;
            end
        end
    end

    // Monitor: track register writes, predict on each request beat,
    // compare each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                n_writes++;
                if (i_cfg_index == CFG_ROOT_ENTRIES)
                    root_entries_reg = i_cfg_data[ROOTENT_W-1:0];
                else
                    reserved_reg = i_cfg_data[RSV_W-1:0];
            end
            if (o_done) begin
                if (layout_q.size() == 0) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display("%0t: result beat with nothing expected, status %0d",
                                 $time, o_status);
                end else begin
                    want = layout_q.pop_front();
                    n_checked++;
                    outcome_hits[want.status]++;
                    check_field("status", want.status, o_status);
                    check_field("sectors_per_cluster", want.spc, o_sectors_per_cluster);
                    check_field("fat_sectors", want.fat, o_fat_sectors);
                    check_field("cluster_count", want.clusters, o_cluster_count);
                    check_field("total_sectors", want.total, o_total_sectors);
                end
            end
            if (i_start && !o_busy)
                layout_q.push_back(solve_layout(i_size_mib));
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", n_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [ROOTENT_W-1:0] phase_root[7];
        logic [CFG_DAT_W-1:0] phase_rsv[7];
        int                   ph;
        int                   k;

        // directed sizes under reset register values: range edges, powers of two,
        // all-zero / all-one bits, and the top size where FAT16 cannot fit
        push_request(12'd0);
        push_request(12'd1);
        push_request(12'd3);
        push_request(12'd4);
        push_request(12'd5);
        push_request(12'd8);
        push_request(12'd16);
        push_request(12'd32);
        push_request(12'd64);
        push_request(12'd128);
        push_request(12'd256);
        push_request(12'd512);
        push_request(12'd1024);
        push_request(12'd1536);
        push_request(12'd2047);
        push_request(12'd2048);
        push_request(12'd2049);
        push_request(12'd4095);
        push_request(12'h555);
        push_request(12'hAAA);

        // register settings per phase; reserved writes above 7 bits are truncated
        phase_root = '{13'd0, 13'h1FFF, 13'd16, 13'd4096, ROOTENT_W'($urandom),
                       ROOTENT_W'($urandom), 13'd512};
        phase_rsv  = '{13'd0, 13'h1FFF, 13'd1, 13'd64, CFG_DAT_W'($urandom),
                       CFG_DAT_W'($urandom), 13'h1F81};
        for (ph = 0; ph < 7; ph++) begin
            push_reg_write(CFG_ROOT_ENTRIES, phase_root[ph]);
            push_reg_write(CFG_RESERVED, phase_rsv[ph]);
            push_request(SIZE_MIN);
            push_request(SIZE_MAX);
            for (k = 0; k < PHASE_REQS; k++) begin
                if (k == PHASE_REQS / 2)
                    push_drain();
                push_request(rand_size());
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (job_q.size() != 0 || i_start || i_cfg_valid || layout_q.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d layouts, %0d register writes, sizes 0..4095, edge and random regs.",
                 n_checked, n_writes);
        $display("Outcomes: %0d fit, %0d size rejected, %0d too small, %0d no FAT16 fit.",
                 outcome_hits[ST_OK], outcome_hits[ST_RANGE], outcome_hits[ST_SMALL],
                 outcome_hits[ST_UNREACH]);
        if (n_err == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
